### rtl/core/periodic_min_priority_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Scheduler core assertion macros
// Shared helpers for the concurrent checks of the scheduler core.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_MIN_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_MIN_PRIORITY_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PMPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/pmps_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler core package
// Field widths, slot record, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pmps_pkg;

	localparam int ID_W  = 16;
	localparam int PER_W = 16;
	localparam int DUE_W = 48;

	localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

	typedef struct packed {
		logic [DUE_W-1:0] due;
		logic [PER_W-1:0] period;
		logic [ID_W-1:0]  id;
	} slot_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SERVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

### rtl/core/pmps_table.sv
// ----------------------------------------------------------------------------
// Client table
// One write port, one registered read port over the slot records.
// ----------------------------------------------------------------------------
`default_nettype none

module pmps_table
	import pmps_pkg::*;
#(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire slot_t             wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output slot_t                  rd_data
);

	slot_t mem_q [DEPTH];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/pmps_alu.sv
// ----------------------------------------------------------------------------
// Scheduler arithmetic unit
// Priority compare of a candidate slot against the best one, and the
// saturating due-time advance of the best slot.
// ----------------------------------------------------------------------------
`default_nettype none

module pmps_alu
	import pmps_pkg::*;
(
	input  wire slot_t             cand,
	input  wire slot_t             best,
	output logic                   better,
	output logic [DUE_W-1:0]       next_due
);

	logic [DUE_W:0] sum;

	assign better = (cand.due < best.due) ||
		((cand.due == best.due) && (cand.id < best.id));

	assign sum      = {1'b0, best.due} + {{(DUE_W+1-PER_W){1'b0}}, best.period};
	assign next_due = sum[DUE_W] ? DUE_MAX : sum[DUE_W-1:0];

endmodule

`default_nettype wire

### rtl/core/periodic_min_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// Periodic minimum-priority scheduler core
// Client table with clear, add and serve commands over a stream port.
// ----------------------------------------------------------------------------
// Clear and add go straight from the transfer to the emit state; serve on a table
// of N clients first scans the table, reading one table entry per cycle through
// a single read port into a single comparator, followed by one write-back of the
// served slot. The core holds one command at a time and takes a new one as soon
// as it is idle, even while the last result waits on the output.
`default_nettype none

`include "periodic_min_priority_scheduler_core_macros.svh"

module periodic_min_priority_scheduler_core
	import pmps_pkg::*;
#(
	parameter int MAX_CLIENTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // client_id[15:0], client_period[31:16]
	input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // served_id[15:0], served_time[63:16]
	output logic [1:0]       m_axis_tuser   // status[1:0]
);

	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	slot_t              best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [ID_W-1:0]    res_id_q;
	logic [DUE_W-1:0]   res_due_q;
	status_t            res_stat_q;
	logic               m_valid_q;
	logic [63:0]        m_data_q;
	logic [1:0]         m_user_q;

	logic               in_xfer;
	cmd_t               cmd;
	logic [ID_W-1:0]    in_id;
	logic [PER_W-1:0]   in_per;
	logic               full;
	logic               rd_en;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	slot_t              wr_data;
	slot_t              rd_data;
	logic               better;
	logic [DUE_W-1:0]   next_due;
	logic               out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);
	assign in_id         = s_axis_tdata[ID_W-1:0];
	assign in_per        = s_axis_tdata[ID_W+PER_W-1:ID_W];
	assign full          = (count_q == CNT_W'(MAX_CLIENTS));
	assign rd_en         = (state_q == ST_SCAN) && (ptr_q < count_q);
	assign out_free      = !m_valid_q || m_axis_tready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = '{due: {{(DUE_W-PER_W){1'b0}}, in_per}, period: in_per, id: in_id};
		if (state_q == ST_UPDATE) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = '{due: next_due, period: best_q.period, id: best_q.id};
		end else if (in_xfer && (cmd == CMD_ADD) && !full) begin
			wr_en = 1'b1;
		end
	end

	pmps_table #(
		.DEPTH  (MAX_CLIENTS),
		.ADDR_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	pmps_alu u_alu (
		.cand     (rd_data),
		.best     (best_q),
		.better   (better),
		.next_due (next_due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			res_id_q   <= '0;
			res_due_q  <= '0;
			res_stat_q <= STAT_OK;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			m_user_q   <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_free && (state_q != ST_EMIT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						res_id_q   <= '0;
						res_due_q  <= '0;
						res_stat_q <= STAT_OK;
						state_q    <= ST_EMIT;
						unique case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_ADD: begin
								if (full) begin
									res_stat_q <= STAT_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_SERVE: begin
								if (count_q == '0) begin
									res_stat_q <= STAT_EMPTY;
								end else begin
									ptr_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_s1 <= ptr_q[IDX_W-1:0];
						ptr_q     <= ptr_q + 1'b1;
					end
					if (rd_vld_s1 && ((rd_idx_s1 == '0) || better)) begin
						best_q     <= rd_data;
						best_idx_q <= rd_idx_s1;
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					res_id_q   <= best_q.id;
					res_due_q  <= best_q.due;
					res_stat_q <= STAT_OK;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {res_due_q, res_id_q};
						m_user_q  <= res_stat_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`PMPS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_CLIENTS), "client count over capacity")
	`PMPS_ASSERT_NOW(a_best_in_table, state_q == ST_UPDATE, {1'b0, best_idx_q} < {1'b0, count_q}, "served slot outside the table")
	`PMPS_ASSERT_NEXT(a_one_at_a_time, in_xfer, !s_axis_tready, "transfer taken while busy")
	`PMPS_ASSERT_NOW(a_due_advances, state_q == ST_UPDATE, next_due >= best_q.due, "due time moved backward")

endmodule

`default_nettype wire
